/* hdl/ppsc_pkg.sv */
// Shared types, constants and helper functions for the plane split clipper.
`timescale 1ns / 1ps

package ppsc_pkg;

    localparam int ATTR_WORDS_DEF = 5;
    localparam int LANES_DEF      = 4;
    localparam int WORDS_IO       = 5;
    localparam int LANES_IO       = 4;
    localparam int POS_W          = 32;
    localparam int ATTR_W         = 64;
    localparam int LANE_W         = 16;
    localparam int DIST_W         = 64;
    localparam int T_W            = 17;
    localparam int DATA_W         = 3 * POS_W + WORDS_IO * ATTR_W;
    localparam int CFG_IDX_W      = 3;
    localparam int FIFO_DEPTH     = 2;

    localparam logic [T_W-1:0] T_ONE = 17'h1_0000;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH   = 3'd6;

    localparam logic [POS_W-1:0] NORMAL_Z_RST = 32'h0001_0000;
    localparam logic [31:0]      THRESH_RST   = 32'd42950;

    localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MIN = -SUM_MAX;

    typedef logic [2:0][POS_W-1:0]         t_pos;
    typedef logic [WORDS_IO-1:0][ATTR_W-1:0] t_attr;

    typedef struct packed {
        t_pos        point;
        t_pos        normal;
        logic [31:0] thresh;
    } t_plane;

    typedef struct packed {
        logic              prime;
        logic              is_in;
        logic [DIST_W-1:0] sdist;
        t_pos              pos;
        t_attr             attr;
    } t_vtx;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} t_fstate;

    typedef enum logic [2:0] {
        B_IDLE, B_EDOT, B_TSET, B_DIV, B_IPOS, B_IATTR, B_EMIT
    } t_bstate;

    // Clamp a 33-bit difference to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Saturating add, symmetric limits of plus and minus (2^63 - 1).
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > SUM_MAX) begin
            r = SUM_MAX[63:0];
        end else if (s < SUM_MIN) begin
            r = SUM_MIN[63:0];
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

    function automatic logic [ATTR_W-1:0] lane_mask(input int lanes);
        logic [ATTR_W-1:0] m;
        m = '0;
        for (int k = 0; k < LANES_IO; k++) begin
            if (k < lanes) m[k*LANE_W +: LANE_W] = '1;
        end
        return m;
    endfunction

endpackage

/* hdl/polygon_plane_split_clipper.sv */
// Top level of the single-plane polygon splitter: configuration registers and stream ports.
`timescale 1ns / 1ps

// Vertices stream in one beat each; a beat with tuser high primes the previous
// vertex with the polygon's last vertex and produces no output. Every other
// beat gives one result (no plane crossing) or three (edge crosses the plane:
// intersection and vertex, routed by tuser to the inner or outer polygon),
// with tlast on the final result of that vertex. The front end accepts a
// vertex, runs it through its one distance multiplier and hands it to a
// two-entry queue before taking the next. The back end outputs a vertex that
// does not cross; one that crosses passes the edge dot product, setup, the
// one-bit-per-cycle division for t if needed, the position lerp, the attribute
// words and three output beats. Configuration must be written only while the
// block is idle, which the block does not enforce; o_cfg_ready is always high.
module polygon_plane_split_clipper import ppsc_pkg::*; #(
    parameter int ATTR_WORDS     = ATTR_WORDS_DEF,
    parameter int LANES_PER_WORD = LANES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // pos_x, pos_y, pos_z, attr_word_0 .. attr_word_4
    input  logic [DATA_W-1:0]    i_s_axis_tdata,
    // prime
    input  logic                 i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_attr_word_0 .. out_attr_word_4
    output logic [DATA_W-1:0]    o_m_axis_tdata,
    // destination
    output logic                 o_m_axis_tuser,
    output logic                 o_m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_plane r_plane;
    t_vtx   w_f_vtx;
    t_vtx   w_q_vtx;
    logic   w_push;
    logic   w_full;
    logic   w_q_valid;
    logic   w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane.point  <= '0;
            r_plane.normal <= {NORMAL_Z_RST, 32'd0, 32'd0};
            r_plane.thresh <= THRESH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_POINT_X:  r_plane.point[0]  <= i_cfg_data;
                REG_POINT_Y:  r_plane.point[1]  <= i_cfg_data;
                REG_POINT_Z:  r_plane.point[2]  <= i_cfg_data;
                REG_NORMAL_X: r_plane.normal[0] <= i_cfg_data;
                REG_NORMAL_Y: r_plane.normal[1] <= i_cfg_data;
                REG_NORMAL_Z: r_plane.normal[2] <= i_cfg_data;
                REG_THRESH:   r_plane.thresh    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ppsc_front #(
        .ATTR_WORDS     (ATTR_WORDS),
        .LANES_PER_WORD (LANES_PER_WORD)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_plane (r_plane),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_prime (i_s_axis_tuser),
        .i_pos   (i_s_axis_tdata[3*POS_W-1:0]),
        .i_attr  (i_s_axis_tdata[DATA_W-1:3*POS_W]),
        .o_push  (w_push),
        .o_vtx   (w_f_vtx),
        .i_full  (w_full)
    );

    ppsc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_f_vtx),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_vtx)
    );

    ppsc_back #(
        .ATTR_WORDS     (ATTR_WORDS),
        .LANES_PER_WORD (LANES_PER_WORD)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_plane   (r_plane),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_vtx),
        .o_q_pop   (w_pop),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_data  (o_m_axis_tdata),
        .o_m_dest  (o_m_axis_tuser),
        .o_m_last  (o_m_axis_tlast)
    );

endmodule

/* hdl/ppsc_front.sv */
// Front end: accepts vertices, computes the signed plane distance and classifies them.
`timescale 1ns / 1ps

module ppsc_front import ppsc_pkg::*; #(
    parameter int ATTR_WORDS     = ATTR_WORDS_DEF,
    parameter int LANES_PER_WORD = LANES_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_plane i_plane,
    input  logic   i_valid,
    output logic   o_ready,
    input  logic   i_prime,
    input  t_pos   i_pos,
    input  t_attr  i_attr,
    output logic   o_push,
    output t_vtx   o_vtx,
    input  logic   i_full
);

    localparam int NW = (ATTR_WORDS < WORDS_IO) ? ATTR_WORDS : WORDS_IO;
    localparam logic [ATTR_W-1:0] MASK = lane_mask(LANES_PER_WORD);

    t_fstate r_state, n_state;
    logic [1:0] r_cnt, n_cnt;

    logic               r_prime;
    t_pos               r_pos;
    t_attr              r_attr;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;

    logic               w_accept;
    logic [1:0]         w_axis;
    logic signed [31:0] w_diff;
    logic signed [63:0] w_prod;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (i_valid) n_state = F_MUL;
            F_MUL:   if (r_cnt == 2'd3) n_state = F_PUSH;
            F_PUSH:  if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
        n_cnt = (r_state == F_MUL && n_state == F_MUL) ? r_cnt + 2'd1 : 2'd0;
    end

    always_comb begin
        o_ready  = (r_state == F_IDLE);
        o_push   = (r_state == F_PUSH) && !i_full;
        w_accept = o_ready && i_valid;
    end

    always_comb begin
        w_axis = (r_cnt == 2'd3) ? 2'd0 : r_cnt;
        w_diff = sat32($signed({r_pos[w_axis][31], r_pos[w_axis]})
                     - $signed({i_plane.point[w_axis][31], i_plane.point[w_axis]}));
        w_prod = w_diff * $signed(i_plane.normal[w_axis]);
    end

    always_comb begin
        o_vtx.prime = r_prime;
        o_vtx.is_in = !r_acc[63];
        o_vtx.sdist = r_acc;
        o_vtx.pos   = r_pos;
        o_vtx.attr  = r_attr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Three products go through one multiplier; each is added to the sum in the next cycle.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prime <= i_prime;
            r_pos   <= i_pos;
            r_acc   <= '0;
            for (int w = 0; w < WORDS_IO; w++) begin
                r_attr[w] <= (w < NW) ? (i_attr[w] & MASK) : '0;
            end
        end
        if (r_state == F_MUL) begin
            r_prod <= w_prod;
            if (r_cnt != 2'd0) r_acc <= sat_add(r_acc, r_prod);
        end
    end

endmodule

/* hdl/ppsc_fifo.sv */
// Short queue of classified vertices between the front end and the back end.
`timescale 1ns / 1ps

module ppsc_fifo import ppsc_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_vtx i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_vtx o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_vtx             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_data;
    end

endmodule

/* hdl/ppsc_back.sv */
// Back end: edge test, intersection parameter, interpolation and result emission.
`timescale 1ns / 1ps

module ppsc_back import ppsc_pkg::*; #(
    parameter int ATTR_WORDS     = ATTR_WORDS_DEF,
    parameter int LANES_PER_WORD = LANES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_plane            i_plane,
    input  logic              i_q_valid,
    input  t_vtx              i_q_data,
    output logic              o_q_pop,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output logic [DATA_W-1:0] o_m_data,
    output logic              o_m_dest,
    output logic              o_m_last
);

    localparam int NW = (ATTR_WORDS < WORDS_IO) ? ATTR_WORDS : WORDS_IO;
    localparam logic [ATTR_W-1:0] MASK = lane_mask(LANES_PER_WORD);

    t_bstate r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [1:0] r_eidx, n_eidx;

    t_vtx               r_cur;
    t_pos               r_prev_pos;
    t_attr              r_prev_attr;
    logic               r_prev_in;
    logic [DIST_W-1:0]  r_prev_dist;

    logic signed [65:0] r_prod;
    logic signed [63:0] r_acc;
    logic [63:0]        r_rem;
    logic [63:0]        r_den;
    logic [15:0]        r_q;
    logic [T_W-1:0]     r_t;
    t_pos               r_ipos;
    t_attr              r_iattr;

    logic              r_ovalid;
    logic [DATA_W-1:0] r_odata;
    logic              r_odest;
    logic              r_olast;

    logic               w_cross;
    logic               w_load;
    logic               w_last;
    logic               w_dest;
    logic               w_use_i;
    logic [1:0]         w_axis;
    logic [1:0]         w_prev_axis;
    logic [2:0]         w_word;
    logic signed [32:0] w_pdiff;
    logic signed [32:0] w_mul_a;
    logic signed [32:0] w_mul_b;
    logic signed [65:0] w_mul;
    logic signed [65:0] w_rnd;
    logic [63:0]        w_mag;
    logic signed [63:0] w_num;
    logic               w_small;
    logic               w_nonpos;
    logic               w_full;
    logic               w_need_div;
    logic [T_W-1:0]     w_t_early;
    logic [63:0]        w_rem2;
    logic               w_qbit;
    logic [63:0]        w_rem_next;
    logic [ATTR_W-1:0]  w_iword;

    assign w_cross = (r_cur.is_in != r_prev_in);

    // Result order: a crossing edge gives three beats, any other vertex one.
    always_comb begin
        w_last  = !w_cross || (r_eidx == 2'd2);
        w_dest  = !r_cur.is_in;
        w_use_i = 1'b0;
        if (w_cross) begin
            case (r_eidx)
                2'd0: begin
                    w_dest  = 1'b0;
                    w_use_i = 1'b1;
                end
                2'd1: begin
                    w_dest  = !r_cur.is_in;
                    w_use_i = !r_cur.is_in;
                end
                default: begin
                    w_dest  = 1'b1;
                    w_use_i = r_cur.is_in;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid && !i_q_data.prime) begin
                    n_state = (i_q_data.is_in != r_prev_in) ? B_EDOT : B_EMIT;
                end
            end
            B_EDOT:  if (r_cnt == 4'd3) n_state = B_TSET;
            B_TSET:  n_state = w_need_div ? B_DIV : B_IPOS;
            B_DIV:   if (r_cnt == 4'd15) n_state = B_IPOS;
            B_IPOS:  if (r_cnt == 4'd3) n_state = B_IATTR;
            B_IATTR: if (r_cnt == 4'(WORDS_IO - 1)) n_state = B_EMIT;
            B_EMIT:  if (w_load && w_last) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
        n_cnt  = (n_state == r_state && r_state != B_IDLE && r_state != B_EMIT)
               ? r_cnt + 4'd1 : 4'd0;
        n_eidx = (r_state != B_EMIT) ? 2'd0 : (w_load ? r_eidx + 2'd1 : r_eidx);
    end

    always_comb begin
        o_q_pop = (r_state == B_IDLE) && i_q_valid;
        w_load  = (r_state == B_EMIT) && (!r_ovalid || i_m_ready);
    end

    // One shared 33 x 33 multiplier serves the edge dot and the position lerp.
    always_comb begin
        w_axis      = (r_cnt[1:0] == 2'd3) ? 2'd0 : r_cnt[1:0];
        w_prev_axis = r_cnt[1:0] - 2'd1;
        w_word      = (r_cnt[2:0] < 3'(WORDS_IO)) ? r_cnt[2:0] : 3'd0;
        w_pdiff     = $signed({r_cur.pos[w_axis][31], r_cur.pos[w_axis]})
                    - $signed({r_prev_pos[w_axis][31], r_prev_pos[w_axis]});
        if (r_state == B_EDOT) begin
            w_mul_a = {w_pdiff[32], sat32(w_pdiff)};
            w_mul_b = {i_plane.normal[w_axis][31], i_plane.normal[w_axis]};
        end else begin
            w_mul_a = w_pdiff;
            w_mul_b = {16'd0, r_t};
        end
        w_mul = w_mul_a * w_mul_b;
        w_rnd = (r_prod + 66'sd32768) >>> 16;
    end

    always_comb begin
        w_mag      = r_acc[63] ? 64'(-r_acc) : r_acc;
        w_num      = r_acc[63] ? $signed(r_prev_dist) : -$signed(r_prev_dist);
        w_small    = (w_mag < {32'd0, i_plane.thresh});
        w_nonpos   = (w_num <= 64'sd0);
        w_full     = ($unsigned(w_num) >= w_mag);
        w_need_div = !w_small && !w_nonpos && !w_full;
        w_t_early  = (!w_small && !w_nonpos && w_full) ? T_ONE : '0;
        w_rem2     = {r_rem[62:0], 1'b0};
        w_qbit     = (w_rem2 >= r_den);
        w_rem_next = w_qbit ? w_rem2 - r_den : w_rem2;
    end

    // Four attribute lanes of one word per cycle.
    always_comb begin
        logic signed [15:0] la;
        logic signed [15:0] lb;
        logic signed [16:0] ld;
        logic signed [34:0] lp;
        logic signed [34:0] lr;
        w_iword = '0;
        for (int k = 0; k < LANES_IO; k++) begin
            la = $signed(r_prev_attr[w_word][k*LANE_W +: LANE_W]);
            lb = $signed(r_cur.attr[w_word][k*LANE_W +: LANE_W]);
            ld = $signed({lb[15], lb}) - $signed({la[15], la});
            lp = ld * $signed({1'b0, r_t});
            lr = (lp + 35'sd32768) >>> 16;
            w_iword[k*LANE_W +: LANE_W] = la + lr[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_cnt       <= 4'd0;
            r_eidx      <= 2'd0;
            r_ovalid    <= 1'b0;
            r_prev_pos  <= '0;
            r_prev_attr <= '0;
            r_prev_in   <= 1'b0;
            r_prev_dist <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_eidx  <= n_eidx;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_ready) begin
                r_ovalid <= 1'b0;
            end
            if (o_q_pop && i_q_data.prime) begin
                r_prev_pos  <= i_q_data.pos;
                r_prev_attr <= i_q_data.attr;
                r_prev_in   <= i_q_data.is_in;
                r_prev_dist <= i_q_data.sdist;
            end else if (w_load && w_last) begin
                r_prev_pos  <= r_cur.pos;
                r_prev_attr <= r_cur.attr;
                r_prev_in   <= r_cur.is_in;
                r_prev_dist <= r_cur.sdist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_data;
            r_acc <= '0;
        end
        case (r_state)
            B_EDOT: begin
                r_prod <= w_mul;
                if (r_cnt != 4'd0) r_acc <= sat_add(r_acc, r_prod[63:0]);
            end
            B_TSET: begin
                r_rem <= w_num;
                r_den <= w_mag;
                r_q   <= '0;
                r_t   <= w_t_early;
            end
            B_DIV: begin
                r_rem <= w_rem_next;
                r_q   <= {r_q[14:0], w_qbit};
                if (r_cnt == 4'd15) r_t <= {1'b0, r_q[14:0], w_qbit};
            end
            B_IPOS: begin
                r_prod <= w_mul;
                if (r_cnt != 4'd0) begin
                    r_ipos[w_prev_axis] <= r_prev_pos[w_prev_axis] + w_rnd[31:0];
                end
            end
            B_IATTR: begin
                r_iattr[w_word] <= (w_word < 3'(NW)) ? (w_iword & MASK) : '0;
            end
            default: begin
            end
        endcase
        if (w_load) begin
            r_odata <= w_use_i ? {r_iattr, r_ipos} : {r_cur.attr, r_cur.pos};
            r_odest <= w_dest;
            r_olast <= w_last;
        end
    end

    assign o_m_valid = r_ovalid;
    assign o_m_data  = r_odata;
    assign o_m_dest  = r_odest;
    assign o_m_last  = r_olast;

`ifndef ASSERT_OFF
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_IPOS) |-> (r_t <= T_ONE))
        else $error("intersection parameter above one");

    a_div_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_cur.is_in != r_prev_in))
        else $error("division started for an edge that does not cross");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_state == B_IDLE))
        else $error("back end did not return to idle after the final beat");
`endif

endmodule

/* test/tb_polygon_plane_split_clipper.sv */
// Self-checking testbench for the single-plane polygon splitter.
`timescale 1ns / 1ps

module tb_polygon_plane_split_clipper;
    import ppsc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint DIST_LIM = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic              dest;
        logic              last;
        logic [DATA_W-1:0] data;
    } t_clip_vtx;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [DATA_W-1:0]    i_s_axis_tdata = '0;
    logic                 i_s_axis_tuser = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [DATA_W-1:0]    o_m_axis_tdata;
    logic                 o_m_axis_tuser;
    logic                 o_m_axis_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    polygon_plane_split_clipper dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Plane settings and the previous vertex as the block should hold them.
    longint     plane_pt[3];
    longint     plane_nrm[3];
    logic [63:0] par_thresh;
    longint     last_pos[3];
    logic [63:0] last_attr[WORDS_IO];
    logic       last_inside;
    longint     last_dist;

    t_clip_vtx  pending_vtx[$];
    int         mismatches = 0;
    int         burst_left = 0;
    int         items_sent = 0;
    int         idle_cycles = 0;
    int         rx_cycle = 0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint add_sat(longint a, longint b);
        if (b > 0 && a > DIST_LIM - b) return DIST_LIM;
        if (b < 0 && a < -DIST_LIM - b) return -DIST_LIM;
        return a + b;
    endfunction

    function automatic longint plane_dot(longint a[3], longint b[3]);
        longint acc;
        acc = 0;
        for (int k = 0; k < 3; k++) acc = add_sat(acc, clamp32(a[k] - b[k]) * plane_nrm[k]);
        return acc;
    endfunction

    // Rounds to nearest with ties upward; the arithmetic shift floors.
    function automatic longint round16(longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic longint crossing_t(longint ds, longint e);
        logic [63:0] mag, rem;
        longint num, den, q;
        mag = (e < 0) ? 64'(-e) : 64'(e);
        if (mag < par_thresh) return 0;
        num = -ds;
        den = e;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (num <= 0) return 0;
        if (num >= den) return 65536;
        rem = 64'(num);
        q = 0;
        for (int b = 15; b >= 0; b--) begin
            rem = rem << 1;
            if (rem >= 64'(den)) begin
                rem = rem - 64'(den);
                q = q | (64'sd1 << b);
            end
        end
        return q;
    endfunction

    function automatic void push_vtx(logic dest, longint p[3], logic [63:0] a[WORDS_IO]);
        t_clip_vtx v;
        t_pos  vp;
        t_attr va;
        for (int k = 0; k < 3; k++) vp[k] = p[k][31:0];
        for (int w = 0; w < WORDS_IO; w++) va[w] = a[w];
        v.dest = dest;
        v.last = 1'b0;
        v.data = {va, vp};
        pending_vtx.push_back(v);
    endfunction

    // Splits the edge from the held vertex to this one and queues its results.
    function automatic void split_edge(logic prime, t_pos pos, t_attr attr);
        longint p[3], ip[3];
        logic [63:0] a[WORDS_IO], ia[WORDS_IO];
        longint cur_dist, t, la, lb, lv;
        logic ins;
        for (int k = 0; k < 3; k++) p[k] = longint'($signed(pos[k]));
        for (int w = 0; w < WORDS_IO; w++) a[w] = attr[w];
        cur_dist = plane_dot(p, plane_pt);
        ins = (cur_dist >= 0);
        if (!prime) begin
            if (ins != last_inside) begin
                t = crossing_t(last_dist, plane_dot(p, last_pos));
                for (int k = 0; k < 3; k++)
                    ip[k] = last_pos[k] + round16(t * (p[k] - last_pos[k]));
                for (int w = 0; w < WORDS_IO; w++) begin
                    for (int k = 0; k < LANES_IO; k++) begin
                        la = longint'($signed(last_attr[w][k*LANE_W +: LANE_W]));
                        lb = longint'($signed(a[w][k*LANE_W +: LANE_W]));
                        lv = la + round16(t * (lb - la));
                        ia[w][k*LANE_W +: LANE_W] = lv[15:0];
                    end
                end
            end
            if (ins && last_inside) begin
                push_vtx(1'b0, p, a);
            end else if (ins) begin
                push_vtx(1'b0, ip, ia);
                push_vtx(1'b0, p, a);
                push_vtx(1'b1, ip, ia);
            end else if (last_inside) begin
                push_vtx(1'b0, ip, ia);
                push_vtx(1'b1, ip, ia);
                push_vtx(1'b1, p, a);
            end else begin
                push_vtx(1'b1, p, a);
            end
            pending_vtx[pending_vtx.size()-1].last = 1'b1;
        end
        last_pos = p;
        last_attr = a;
        last_inside = ins;
        last_dist = cur_dist;
    endfunction

    // Receiver: cycles through always-ready, half-rate and sparse-ready stretches.
    always @(posedge i_clk) begin
        t_clip_vtx e;
        logic [63:0] ev, av;
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 97) % 3)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= 1'($urandom_range(0, 1));
            default: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_vtx.size() == 0) begin
                if (mismatches < 10) $display("unexpected output beat: tuser %0b tlast %0b",
                                               o_m_axis_tuser, o_m_axis_tlast);
                mismatches++;
            end else begin
                e = pending_vtx.pop_front();
                if (e.dest !== o_m_axis_tuser || e.last !== o_m_axis_tlast) begin
                    if (mismatches < 10)
                        $display("dest/last mismatch: expected %0b/%0b got %0b/%0b",
                                 e.dest, e.last, o_m_axis_tuser, o_m_axis_tlast);
                    mismatches++;
                end
                for (int f = 0; f < 8; f++) begin
                    if (f < 3) begin
                        ev = 64'(e.data[f*POS_W +: POS_W]);
                        av = 64'(o_m_axis_tdata[f*POS_W +: POS_W]);
                    end else begin
                        ev = e.data[3*POS_W + (f-3)*ATTR_W +: ATTR_W];
                        av = o_m_axis_tdata[3*POS_W + (f-3)*ATTR_W +: ATTR_W];
                    end
                    if (ev !== av) begin
                        if (mismatches < 10)
                            $display("field %0d mismatch: expected %h got %h", f, ev, av);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("polygon_plane_split_clipper test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_vertex(logic prime, t_pos pos, t_attr attr);
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {attr, pos};
        i_s_axis_tuser  <= prime;
        do @(posedge i_clk); while (!o_s_axis_tready);
        split_edge(prime, pos, attr);
        burst_left--;
        items_sent++;
    endtask

    // Stops sending and waits for every queued result plus the back end settling.
    task automatic drain_outputs();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_vtx.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_POINT_X, REG_POINT_Y, REG_POINT_Z: plane_pt[idx] = longint'($signed(val));
            REG_NORMAL_X, REG_NORMAL_Y, REG_NORMAL_Z:
                plane_nrm[idx - REG_NORMAL_X] = longint'($signed(val));
            REG_THRESH: par_thresh = 64'(val);
            default: ;
        endcase
    endtask

    task automatic set_plane(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                             logic [31:0] th);
        drain_outputs();
        write_reg(REG_POINT_X, px);
        write_reg(REG_POINT_Y, py);
        write_reg(REG_POINT_Z, pz);
        write_reg(REG_NORMAL_X, nx);
        write_reg(REG_NORMAL_Y, ny);
        write_reg(REG_NORMAL_Z, nz);
        write_reg(REG_THRESH, th);
    endtask

    function automatic t_pos mk_pos(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_pos p;
        p[0] = x;
        p[1] = y;
        p[2] = z;
        return p;
    endfunction

    function automatic t_attr fill_attr(logic [63:0] v);
        t_attr a;
        for (int w = 0; w < WORDS_IO; w++) a[w] = v;
        return a;
    endfunction

    function automatic t_attr rand_attr();
        t_attr a;
        for (int w = 0; w < WORDS_IO; w++) a[w] = {$urandom, $urandom};
        return a;
    endfunction

    // Mostly small coordinates near the plane, now and then any 32-bit value.
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 5) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    endfunction

    function automatic logic [31:0] rand_normal();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
    endfunction

    // Edges leaving the reset vertex, then full-scale coordinates and attribute lanes.
    task automatic test_unprimed_start();
        send_vertex(1'b0, mk_pos('0, '0, 32'h0001_0000), fill_attr('1));
        send_vertex(1'b0, mk_pos(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000),
                    fill_attr(64'h8000_8000_8000_8000));
        send_vertex(1'b0, mk_pos(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
                    fill_attr(64'h7FFF_7FFF_7FFF_7FFF));
        send_vertex(1'b0, mk_pos('0, '0, '0), fill_attr('0));
        send_vertex(1'b0, mk_pos('1, '1, 32'hFFFF_0000), fill_attr(64'h0123_4567_89AB_CDEF));
    endtask

    // A primed quadrilateral straddling the default plane: all four inside/outside cases.
    task automatic test_primed_square();
        send_vertex(1'b1, mk_pos(32'h0001_0000, '0, 32'hFFFE_0000), fill_attr('0));
        send_vertex(1'b0, mk_pos(32'h0001_0000, '0, 32'h0003_0000), fill_attr('1));
        send_vertex(1'b0, mk_pos('0, '0, 32'h0001_0000), fill_attr(64'h7FFF_0000_8000_1234));
        send_vertex(1'b0, mk_pos('0, 32'h0001_0000, 32'hFFFF_8000), fill_attr('0));
        send_vertex(1'b0, mk_pos(32'h0001_0000, '0, 32'hFFFE_0000), rand_attr());
        drain_outputs();
    endtask

    // Extreme plane settings, a threshold that forces t to zero, and an unused index.
    task automatic test_plane_extremes();
        set_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0);
        send_vertex(1'b1, mk_pos(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), rand_attr());
        send_vertex(1'b0, mk_pos(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000), rand_attr());
        send_vertex(1'b0, mk_pos(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), rand_attr());
        set_plane('0, '0, '0, '0, '0, 32'h0001_0000, '1);
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        send_vertex(1'b1, mk_pos('0, '0, 32'h0002_0000), rand_attr());
        send_vertex(1'b0, mk_pos('0, '0, 32'hFFFE_0000), rand_attr());
        send_vertex(1'b0, mk_pos('0, '0, 32'h0000_0001), rand_attr());
        set_plane(32'h0000_8000, 32'hFFFF_0000, '0,
                  32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, THRESH_RST);
        send_vertex(1'b1, mk_pos('0, '0, '0), rand_attr());
        send_vertex(1'b0, mk_pos(32'h0002_0000, '0, '0), rand_attr());
        send_vertex(1'b0, mk_pos(32'hFFFE_0000, '0, '0), rand_attr());
    endtask

    task automatic test_random_polygons(int target);
        t_pos  vp[8];
        t_attr va[8];
        int    nv;
        while (items_sent < target) begin
            if ($urandom_range(0, 39) == 0) begin
                // Occasional new plane; the drain also holds the sender off.
                set_plane(rand_coord(), rand_coord(), rand_coord(),
                          rand_normal(), rand_normal(), rand_normal(),
                          ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100000));
            end
            if ($urandom_range(0, 9) == 0) begin
                send_vertex(1'($urandom_range(0, 1)),
                            mk_pos(rand_coord(), rand_coord(), rand_coord()), rand_attr());
            end else begin
                nv = $urandom_range(3, 8);
                for (int k = 0; k < nv; k++) begin
                    vp[k] = mk_pos(rand_coord(), rand_coord(), rand_coord());
                    va[k] = rand_attr();
                end
                send_vertex(1'b1, vp[nv-1], va[nv-1]);
                for (int k = 0; k < nv; k++) send_vertex(1'b0, vp[k], va[k]);
            end
        end
    endtask

    initial begin
        plane_pt = '{0, 0, 0};
        plane_nrm = '{0, 0, 65536};
        par_thresh = 64'(THRESH_RST);
        last_pos = '{0, 0, 0};
        for (int w = 0; w < WORDS_IO; w++) last_attr[w] = '0;
        last_inside = 1'b0;
        last_dist = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_unprimed_start();
        test_primed_square();
        test_plane_extremes();
        test_random_polygons(330);
        drain_outputs();
        if (mismatches == 0) begin
            $display("polygon_plane_split_clipper test passed");
        end else begin
            $display("polygon_plane_split_clipper test failed");
        end
        $finish;
    end

endmodule
